FILE: hdl/sha1_compression_core_defines.svh
// Assertion macros shared by the SHA-1 compression core.
`ifndef SHA1_COMPRESSION_CORE_DEFINES_SVH
`define SHA1_COMPRESSION_CORE_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define SHA1C_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define SHA1C_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: hdl/sha1c_pkg.sv
// Shared types and constants of the SHA-1 compression core.
`default_nettype none
package sha1c_pkg;
	localparam int WORD_W     = 32;
	localparam int BLK_WORDS  = 16;
	localparam int IDX_W      = $clog2(BLK_WORDS);
	localparam int SLOTS      = 2;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int RAM_DEPTH  = SLOTS * BLK_WORDS;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int ROUNDS     = 80;
	localparam int RND_W      = $clog2(ROUNDS);
	localparam int STAGE_LEN  = 20;
	localparam int HASH_WORDS = 5;
	localparam int OIDX_W     = 3;
	localparam int CFG_IDX_W  = 2;

	localparam logic [WORD_W-1:0] HASH_INIT [HASH_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [WORD_W-1:0] K_RESET [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_K0 = 2'd0,
		REG_K1 = 2'd1,
		REG_K2 = 2'd2,
		REG_K3 = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROUND,
		B_ADD
	} back_state_t;

	// Block flags: bit 0 is first, bit 1 is last.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] data;
		logic              commit;
		logic [1:0]        flags;
	} bq_wr_t;

	typedef struct packed {
		logic             release_blk;
		logic [IDX_W-1:0] idx;
	} bq_rd_t;

	typedef struct packed {
		logic       avail;
		logic [1:0] flags;
	} bq_st_t;
endpackage
`default_nettype wire

FILE: hdl/sha1_compression_core.sv
// SHA-1 compression core: one message word per item, up to five digest words per block.
// Words enter a two-block queue one per clock while not full; full means both slots are held.
// A block passes the round engine in steps (start, 80 rounds at one per cycle, hash add);
// the hash add of a last block waits while the digest buffer still holds unpopped words.
// The first digest word appears once the hash add of a last block has loaded the digest buffer.
// Reset loads the standard initial hash and round constants and empties both queues.
`default_nettype none
module sha1_compression_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [sha1c_pkg::WORD_W-1:0]        message_word,
	input  wire logic                                first_block,
	input  wire logic                                last_block,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [sha1c_pkg::WORD_W-1:0]             digest_word,
	output logic [2:0]                               digest_index,
	output logic                                     digest_last,
	input  wire logic                                cfg_we,
	input  wire logic [sha1c_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sha1c_pkg::WORD_W-1:0]        cfg_data
);
	sha1c_pkg::bq_wr_t           wr;
	sha1c_pkg::bq_rd_t           rd;
	sha1c_pkg::bq_st_t           st;
	logic [sha1c_pkg::WORD_W-1:0] rd_data;

	sha1c_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.message_word(message_word),
		.first_block (first_block),
		.last_block  (last_block),
		.wr          (wr)
	);

	sha1c_blkq u_blkq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.rd     (rd),
		.st     (st),
		.rd_data(rd_data)
	);

	sha1c_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.st          (st),
		.rd_data     (rd_data),
		.rd          (rd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.digest_index(digest_index),
		.digest_last (digest_last)
	);
endmodule
`default_nettype wire

FILE: hdl/sha1c_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sha1c_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/sha1c_front.sv
// Input side: counts words within a block and collects the block flags.
`default_nettype none
module sha1c_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire logic                             full,
	input  wire logic [sha1c_pkg::WORD_W-1:0]     message_word,
	input  wire logic                             first_block,
	input  wire logic                             last_block,
	output sha1c_pkg::bq_wr_t                     wr
);
	logic [sha1c_pkg::IDX_W-1:0] word_cnt_q;
	logic [1:0]                  flags_q;
	logic                        accept;
	logic                        blk_end;
	logic [1:0]                  flags_all;

	assign accept    = push && !full;
	assign blk_end   = (word_cnt_q == sha1c_pkg::IDX_W'(sha1c_pkg::BLK_WORDS - 1));
	assign flags_all = flags_q | {last_block, first_block};

	always_comb begin
		wr.en     = accept;
		wr.idx    = word_cnt_q;
		wr.data   = message_word;
		wr.commit = accept && blk_end;
		wr.flags  = flags_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q <= '0;
			flags_q    <= '0;
		end else if (accept) begin
			word_cnt_q <= word_cnt_q + 1'b1;
			flags_q    <= blk_end ? 2'b00 : flags_all;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sha1c_blkq.sv
// Two-block queue between the input side and the round engine.
`default_nettype none
`include "sha1_compression_core_defines.svh"
module sha1c_blkq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sha1c_pkg::bq_wr_t            wr,
	output logic                              full,
	input  wire sha1c_pkg::bq_rd_t            rd,
	output sha1c_pkg::bq_st_t                 st,
	output logic [sha1c_pkg::WORD_W-1:0]      rd_data
);
	logic [sha1c_pkg::SLOT_W-1:0] wr_slot_q;
	logic [sha1c_pkg::SLOT_W-1:0] rd_slot_q;
	logic [sha1c_pkg::CNT_W-1:0]  cnt_q;
	logic [1:0]                   flg_q [sha1c_pkg::SLOTS];

	assign full     = (cnt_q == sha1c_pkg::CNT_W'(sha1c_pkg::SLOTS));
	assign st.avail = (cnt_q != '0);
	assign st.flags = flg_q[rd_slot_q];

	sha1c_ram #(
		.WIDTH(sha1c_pkg::WORD_W),
		.DEPTH(sha1c_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr({wr_slot_q, wr.idx}),
		.wdata(wr.data),
		.raddr({rd_slot_q, rd.idx}),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			cnt_q     <= '0;
			for (int i = 0; i < sha1c_pkg::SLOTS; i++) begin
				flg_q[i] <= '0;
			end
		end else begin
			if (wr.commit) begin
				flg_q[wr_slot_q] <= wr.flags;
				wr_slot_q        <= wr_slot_q + 1'b1;
			end
			if (rd.release_blk) begin
				rd_slot_q <= rd_slot_q + 1'b1;
			end
			if (wr.commit && !rd.release_blk) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr.commit && rd.release_blk) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SHA1C_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= sha1c_pkg::CNT_W'(sha1c_pkg::SLOTS), "block queue overfilled")
	`SHA1C_ASSERT_NOW(a_rel_nonempty, rd.release_blk, cnt_q != '0, "release of an empty block queue")
	`SHA1C_ASSERT_NOW(a_no_write_full, wr.en, !full, "word written into a full block queue")
endmodule
`default_nettype wire

FILE: hdl/sha1c_back.sv
// Round engine: schedule expansion, 80 rounds, hash update and digest buffer.
`default_nettype none
`include "sha1_compression_core_defines.svh"
module sha1c_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sha1c_pkg::bq_st_t                   st,
	input  wire logic [sha1c_pkg::WORD_W-1:0]        rd_data,
	output sha1c_pkg::bq_rd_t                        rd,
	input  wire logic                                cfg_we,
	input  wire logic [sha1c_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sha1c_pkg::WORD_W-1:0]        cfg_data,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [sha1c_pkg::WORD_W-1:0]             digest_word,
	output logic [2:0]                               digest_index,
	output logic                                     digest_last
);
	localparam int W = sha1c_pkg::WORD_W;
	localparam int N = sha1c_pkg::HASH_WORDS;

	sha1c_pkg::back_state_t state_q, state_d;

	logic [W-1:0] k_q    [4];
	logic [W-1:0] hash_q [N];
	logic [W-1:0] v_q    [N];
	logic [W-1:0] w_q    [sha1c_pkg::BLK_WORDS];
	logic [W-1:0] dg_q   [N];
	logic [sha1c_pkg::RND_W-1:0]  rnd_q;
	logic [sha1c_pkg::OIDX_W-1:0] oidx_q;
	logic                         busy_q;

	logic         start;
	logic         finish;
	logic         load_out;
	logic [W-1:0] w_exp;
	logic [W-1:0] w_t;
	logic [W-1:0] f_val;
	logic [W-1:0] k_sel;
	logic [W-1:0] t_val;
	logic [W-1:0] sum [N];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1c_pkg::B_IDLE: begin
				if (st.avail) state_d = sha1c_pkg::B_ROUND;
			end
			sha1c_pkg::B_ROUND: begin
				if (rnd_q == sha1c_pkg::RND_W'(sha1c_pkg::ROUNDS - 1)) state_d = sha1c_pkg::B_ADD;
			end
			sha1c_pkg::B_ADD: begin
				if (!(st.flags[1] && busy_q)) state_d = sha1c_pkg::B_IDLE;
			end
			default: state_d = sha1c_pkg::B_IDLE;
		endcase
	end

	// Control strobes.
	always_comb begin
		start          = 1'b0;
		finish         = 1'b0;
		load_out       = 1'b0;
		rd.release_blk = 1'b0;
		rd.idx         = '0;
		unique case (state_q)
			sha1c_pkg::B_IDLE: begin
				start = st.avail;
			end
			sha1c_pkg::B_ROUND: begin
				// The RAM read is registered, so fetch the word for the next round.
				rd.idx = rnd_q[sha1c_pkg::IDX_W-1:0] + 1'b1;
			end
			sha1c_pkg::B_ADD: begin
				finish         = !(st.flags[1] && busy_q);
				load_out       = finish && st.flags[1];
				rd.release_blk = finish;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	assign w_exp = {w_q[13][W-2:0] ^ w_q[8][W-2:0] ^ w_q[2][W-2:0] ^ w_q[0][W-2:0],
		w_q[13][W-1] ^ w_q[8][W-1] ^ w_q[2][W-1] ^ w_q[0][W-1]};
	assign w_t   = (rnd_q < sha1c_pkg::RND_W'(sha1c_pkg::BLK_WORDS)) ? rd_data : w_exp;

	always_comb begin
		if (rnd_q < sha1c_pkg::RND_W'(sha1c_pkg::STAGE_LEN)) begin
			f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k_sel = k_q[0];
		end else if (rnd_q < sha1c_pkg::RND_W'(2 * sha1c_pkg::STAGE_LEN)) begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_sel = k_q[1];
		end else if (rnd_q < sha1c_pkg::RND_W'(3 * sha1c_pkg::STAGE_LEN)) begin
			f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k_sel = k_q[2];
		end else begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_sel = k_q[3];
		end
	end

	assign t_val = {v_q[0][W-6:0], v_q[0][W-1:W-5]} + f_val + v_q[4] + k_sel + w_t;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			sum[i] = hash_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1c_pkg::B_IDLE;
			rnd_q   <= '0;
			oidx_q  <= '0;
			busy_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				k_q[i] <= sha1c_pkg::K_RESET[i];
			end
			for (int i = 0; i < N; i++) begin
				hash_q[i] <= sha1c_pkg::HASH_INIT[i];
				v_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (sha1c_pkg::reg_idx_t'(cfg_index))
					sha1c_pkg::REG_K0: k_q[0] <= cfg_data;
					sha1c_pkg::REG_K1: k_q[1] <= cfg_data;
					sha1c_pkg::REG_K2: k_q[2] <= cfg_data;
					sha1c_pkg::REG_K3: k_q[3] <= cfg_data;
					default: k_q[0] <= k_q[0];
				endcase
			end
			if (start) begin
				rnd_q <= '0;
				for (int i = 0; i < N; i++) begin
					if (st.flags[0]) begin
						hash_q[i] <= sha1c_pkg::HASH_INIT[i];
						v_q[i]    <= sha1c_pkg::HASH_INIT[i];
					end else begin
						v_q[i] <= hash_q[i];
					end
				end
			end else if (state_q == sha1c_pkg::B_ROUND) begin
				rnd_q  <= rnd_q + 1'b1;
				v_q[0] <= t_val;
				v_q[1] <= v_q[0];
				v_q[2] <= {v_q[1][1:0], v_q[1][W-1:2]};
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3];
			end
			if (finish) begin
				for (int i = 0; i < N; i++) begin
					hash_q[i] <= sum[i];
				end
			end
			if (load_out) begin
				busy_q <= 1'b1;
				oidx_q <= '0;
			end else if (pop && busy_q) begin
				if (oidx_q == sha1c_pkg::OIDX_W'(N - 1)) begin
					busy_q <= 1'b0;
				end
				oidx_q <= oidx_q + 1'b1;
			end
		end
	end

	// Schedule window and digest buffer hold payload only.
	always_ff @(posedge clk) begin
		if (state_q == sha1c_pkg::B_ROUND) begin
			for (int i = 0; i < sha1c_pkg::BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha1c_pkg::BLK_WORDS - 1] <= w_t;
		end
		if (load_out) begin
			for (int i = 0; i < N; i++) begin
				dg_q[i] <= sum[i];
			end
		end
	end

	assign empty        = !busy_q;
	assign digest_word  = dg_q[oidx_q];
	assign digest_index = oidx_q;
	assign digest_last  = (oidx_q == sha1c_pkg::OIDX_W'(N - 1));

	`SHA1C_ASSERT_NOW(a_rnd_range, state_q == sha1c_pkg::B_ROUND, rnd_q < sha1c_pkg::RND_W'(sha1c_pkg::ROUNDS), "round counter out of range")
	`SHA1C_ASSERT_NOW(a_oidx_range, busy_q, oidx_q < sha1c_pkg::OIDX_W'(N), "digest index out of range")
	`SHA1C_ASSERT_NEXT(a_out_hold, busy_q && !pop, busy_q && $stable(oidx_q), "digest word dropped without pop")
endmodule
`default_nettype wire
